// File: design/mpfb_pkg.sv
// mpfb_pkg: shared types and constants for the page framebuffer draw core
// field widths, command/color codes and sequencer states; no dependencies

package mpfb_pkg;

  localparam int DEF_SCREEN_WIDTH  = 128;
  localparam int DEF_SCREEN_HEIGHT = 64;

  localparam int CMD_W    = 3;
  localparam int X_W      = 7;
  localparam int Y_W      = 6;
  localparam int RECT_W_W = 8;
  localparam int RECT_H_W = 7;
  localparam int COLOR_W  = 2;
  localparam int BIDX_W   = 10;
  localparam int DATA_W   = 8;
  localparam int STATUS_W = 1;

  localparam int PAGE_ROWS = 8;
  localparam int ROW_SEL_W = 3;

  localparam logic [DATA_W-1:0] FILL_ONES = 8'hFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 3'd0,
    CMD_FILL  = 3'd1,
    CMD_PIXEL = 3'd2,
    CMD_HLINE = 3'd3,
    CMD_VLINE = 3'd4,
    CMD_RECT  = 3'd5,
    CMD_READ  = 3'd6
  } cmd_t;

  typedef enum logic [COLOR_W-1:0] {
    PEN_OFF  = 2'd0,
    PEN_ON   = 2'd1,
    PEN_FLIP = 2'd2
  } color_t;

  // pen code that leaves every pixel as it is
  localparam logic [COLOR_W-1:0] PEN_NONE = 2'd3;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_RD,
    ST_WR,
    ST_FIN
  } state_t;

endpackage

// File: design/mpfb_if.sv
// mpfb_in_if / mpfb_out_if: valid/ready channels of the draw core
// depends on mpfb_pkg for field widths

interface mpfb_in_if;
  logic                            valid;
  logic                            ready;
  logic [mpfb_pkg::CMD_W-1:0]      command;
  logic [mpfb_pkg::X_W-1:0]        x_a;
  logic [mpfb_pkg::Y_W-1:0]        y_a;
  logic [mpfb_pkg::X_W-1:0]        x_b;
  logic [mpfb_pkg::Y_W-1:0]        y_b;
  logic [mpfb_pkg::RECT_W_W-1:0]   rect_w;
  logic [mpfb_pkg::RECT_H_W-1:0]   rect_h;
  logic [mpfb_pkg::COLOR_W-1:0]    color;
  logic [mpfb_pkg::BIDX_W-1:0]     byte_index;

  modport source (output valid, command, x_a, y_a, x_b, y_b, rect_w, rect_h, color,
                  byte_index, input ready);
  modport sink   (input valid, command, x_a, y_a, x_b, y_b, rect_w, rect_h, color,
                  byte_index, output ready);
endinterface

interface mpfb_out_if;
  logic                            valid;
  logic                            ready;
  logic [mpfb_pkg::DATA_W-1:0]     read_data;
  logic [mpfb_pkg::STATUS_W-1:0]   status;

  modport source (output valid, read_data, status, input ready);
  modport sink   (input valid, read_data, status, output ready);
endinterface

// File: design/mono_page_framebuffer_draw_core.sv
// mono_page_framebuffer_draw_core: 1-bit page framebuffer with draw commands
// depends on mpfb_pkg and the mpfb_in_if / mpfb_out_if channel interfaces
//
//   channel    dir  handshake      payload
//   in_chan    in   valid/ready    command, x_a, y_a, x_b, y_b, rect_w, rect_h, color, byte_index
//   out_chan   out  valid/ready    read_data, status
//
// one item at a time; ready only while idle, a result may wait in the output register
// clear / fill: one store byte per cycle over the whole store
// draws: read-modify-write (ST_RD then ST_WR) of each byte, one byte per column and page touched
// read byte: one ST_RD step then ST_FIN; rejected or no-op items go straight to ST_FIN
// after reset a zeroing sweep over all STORE_BYTES bytes runs before the first item is taken

module mono_page_framebuffer_draw_core #(
  parameter int SCREEN_WIDTH  = mpfb_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = mpfb_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic        clk,
  input  logic        rst_n,
  mpfb_in_if.sink     in_chan,
  mpfb_out_if.source  out_chan
);
  import mpfb_pkg::*;

  localparam int PAGE_COUNT  = (SCREEN_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
  localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
  localparam int AW  = $clog2(STORE_BYTES);
  localparam int CW  = $clog2(SCREEN_WIDTH);
  localparam int RW  = $clog2(SCREEN_HEIGHT);
  localparam int PW  = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int RPW = PW + ROW_SEL_W;

  state_t state_r, state_nxt;

  logic [AW-1:0]     addr_r;
  logic [AW-1:0]     base_r;
  logic [CW-1:0]     col_r, x0_r, x1_r;
  logic [PW-1:0]     page_r, pl_r;
  logic [RW-1:0]     y0_r, y1_r;
  color_t            color_r;
  logic [DATA_W-1:0] fill_r;
  logic              sweep_res_r;
  logic              is_read_r;
  logic              res_status_r;

  logic [DATA_W-1:0] frame_mem [STORE_BYTES];
  logic [DATA_W-1:0] rd_data_r;

  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;
  logic              out_status_r;

  // accept-side decode
  logic [8:0]        d_xlo, d_xhi;
  logic [7:0]        d_ylo, d_yhi;
  logic              d_bad, d_empty, d_is_draw, d_draw, d_sweep, d_read_ok;
  logic [AW-1:0]     d_base;
  logic              in_fire;

  // sequencer outputs
  logic              mem_we;
  logic [DATA_W-1:0] mem_wdata;
  logic [DATA_W-1:0] row_mask;
  logic              col_last, page_last, out_load;

  assign in_fire = in_chan.valid && in_chan.ready;

  always_comb begin
    d_xlo     = {2'b00, in_chan.x_a};
    d_xhi     = {2'b00, in_chan.x_a};
    d_ylo     = {2'b00, in_chan.y_a};
    d_yhi     = {2'b00, in_chan.y_a};
    d_bad     = 1'b0;
    d_empty   = 1'b0;
    d_is_draw = 1'b0;
    d_sweep   = 1'b0;
    d_read_ok = 1'b0;
    unique case (cmd_t'(in_chan.command))
      CMD_CLEAR, CMD_FILL: begin
        d_sweep = 1'b1;
      end
      CMD_PIXEL: begin
        d_is_draw = 1'b1;
        d_bad = (int'(d_xlo) >= SCREEN_WIDTH) || (int'(d_ylo) >= SCREEN_HEIGHT);
      end
      CMD_HLINE: begin
        d_is_draw = 1'b1;
        if (in_chan.x_a > in_chan.x_b) begin
          d_xlo = {2'b00, in_chan.x_b};
        end else begin
          d_xhi = {2'b00, in_chan.x_b};
        end
        d_bad = (int'(d_xhi) >= SCREEN_WIDTH) || (int'(d_ylo) >= SCREEN_HEIGHT);
      end
      CMD_VLINE: begin
        d_is_draw = 1'b1;
        if (in_chan.y_a > in_chan.y_b) begin
          d_ylo = {2'b00, in_chan.y_b};
        end else begin
          d_yhi = {2'b00, in_chan.y_b};
        end
        d_bad = (int'(d_xlo) >= SCREEN_WIDTH) || (int'(d_yhi) >= SCREEN_HEIGHT);
      end
      CMD_RECT: begin
        d_is_draw = 1'b1;
        d_xhi   = d_xlo + {1'b0, in_chan.rect_w} - 9'd1;
        d_yhi   = d_ylo + {1'b0, in_chan.rect_h} - 8'd1;
        d_empty = (in_chan.rect_w == '0) || (in_chan.rect_h == '0);
        d_bad   = (int'(d_xlo) >= SCREEN_WIDTH) || (int'(d_ylo) >= SCREEN_HEIGHT) ||
                  ((in_chan.rect_w != '0) && (int'(d_xhi) >= SCREEN_WIDTH)) ||
                  ((in_chan.rect_h != '0) && (int'(d_yhi) >= SCREEN_HEIGHT));
      end
      CMD_READ: begin
        d_bad     = int'(in_chan.byte_index) >= STORE_BYTES;
        d_read_ok = !d_bad;
      end
      default: begin
      end
    endcase
    d_draw = d_is_draw && !d_bad && !d_empty && (in_chan.color != PEN_NONE);
    d_base = AW'(int'(PW'(d_ylo >> ROW_SEL_W)) * SCREEN_WIDTH);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_SWEEP: begin
        if (addr_r == AW'(STORE_BYTES - 1)) begin
          state_nxt = sweep_res_r ? ST_FIN : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (d_sweep) begin
            state_nxt = ST_SWEEP;
          end else if (d_draw || d_read_ok) begin
            state_nxt = ST_RD;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_RD: begin
        state_nxt = is_read_r ? ST_FIN : ST_WR;
      end
      ST_WR: begin
        state_nxt = (col_last && page_last) ? ST_FIN : ST_RD;
      end
      ST_FIN: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    logic [RPW-1:0] row;
    row       = '0;
    row_mask  = '0;
    for (int j = 0; j < PAGE_ROWS; j++) begin
      row = {page_r, ROW_SEL_W'(j)};
      row_mask[j] = (row >= RPW'(y0_r)) && (row <= RPW'(y1_r));
    end
    col_last      = (col_r == x1_r);
    page_last     = (page_r == pl_r);
    in_chan.ready = (state_r == ST_IDLE);
    out_load      = (state_r == ST_FIN) && (!out_valid_r || out_chan.ready);
    mem_we        = (state_r == ST_SWEEP) || (state_r == ST_WR);
    if (state_r == ST_SWEEP) begin
      mem_wdata = fill_r;
    end else begin
      unique case (color_r)
        PEN_OFF:  mem_wdata = rd_data_r & ~row_mask;
        PEN_ON:   mem_wdata = rd_data_r | row_mask;
        PEN_FLIP: mem_wdata = rd_data_r ^ row_mask;
        default:  mem_wdata = rd_data_r;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      addr_r      <= '0;
      fill_r      <= '0;
      sweep_res_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_SWEEP: begin
          addr_r <= addr_r + AW'(1);
        end
        ST_IDLE: begin
          if (in_fire) begin
            if (d_sweep) begin
              addr_r      <= '0;
              sweep_res_r <= 1'b1;
              fill_r      <= (cmd_t'(in_chan.command) == CMD_FILL) ? FILL_ONES : '0;
            end else if (d_read_ok) begin
              addr_r <= AW'(in_chan.byte_index);
            end else begin
              addr_r <= d_base + AW'(d_xlo);
            end
          end
        end
        ST_WR: begin
          if (!col_last) begin
            addr_r <= addr_r + AW'(1);
          end else if (!page_last) begin
            addr_r <= base_r + AW'(SCREEN_WIDTH) + AW'(x0_r);
          end
        end
        default: begin
        end
      endcase
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // walk and item registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_fire) begin
      is_read_r    <= (cmd_t'(in_chan.command) == CMD_READ);
      res_status_r <= d_bad;
      x0_r         <= CW'(d_xlo);
      x1_r         <= CW'(d_xhi);
      col_r        <= CW'(d_xlo);
      y0_r         <= RW'(d_ylo);
      y1_r         <= RW'(d_yhi);
      page_r       <= PW'(d_ylo >> ROW_SEL_W);
      pl_r         <= PW'(d_yhi >> ROW_SEL_W);
      base_r       <= d_base;
      color_r      <= color_t'(in_chan.color);
    end else if (state_r == ST_WR) begin
      if (!col_last) begin
        col_r <= col_r + CW'(1);
      end else if (!page_last) begin
        col_r  <= x0_r;
        page_r <= page_r + PW'(1);
        base_r <= base_r + AW'(SCREEN_WIDTH);
      end
    end
  end

  // frame store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[addr_r] <= mem_wdata;
    end
    rd_data_r <= frame_mem[addr_r];
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r   <= (is_read_r && !res_status_r) ? rd_data_r : '0;
      out_status_r <= res_status_r;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.read_data = out_data_r;
  assign out_chan.status    = out_status_r;

  a_wr_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WR) |-> (int'(addr_r) < STORE_BYTES))
    else $error("write address beyond store");

  a_walk_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_RD || state_r == ST_WR) && !is_read_r) |->
      (col_r >= x0_r && col_r <= x1_r && page_r <= pl_r))
    else $error("draw walk outside its box");

  a_reject_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.status == 1'b1) |-> (out_chan.read_data == '0))
    else $error("rejected item carries data");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != ST_IDLE))
    else $error("accepted item left no work");

endmodule

// File: test/tb_top.sv
// tb_top: self-checking bench for the mono page framebuffer draw core
// random and directed draw/read commands, a shadow framebuffer predicts each reply
// depends on mpfb_pkg, mpfb_in_if / mpfb_out_if and mono_page_framebuffer_draw_core

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mpfb_pkg::*;

  localparam int SCR_W        = DEF_SCREEN_WIDTH;
  localparam int SCR_H        = DEF_SCREEN_HEIGHT;
  localparam int PAGES        = (SCR_H + PAGE_ROWS - 1) / PAGE_ROWS;
  localparam int FB_BYTES     = SCR_W * PAGES;
  localparam int RANDOM_ITEMS = 1500;
  localparam int MAX_IDLE     = 10;
  localparam int DRAIN_CYCLES = 50;
  localparam int SEGMENT_LEN  = 50;

  localparam logic [CMD_W-1:0]   CMD_NOP    = 3'd7;

  typedef struct {
    logic [CMD_W-1:0]    command;
    logic [X_W-1:0]      x_a;
    logic [Y_W-1:0]      y_a;
    logic [X_W-1:0]      x_b;
    logic [Y_W-1:0]      y_b;
    logic [RECT_W_W-1:0] rect_w;
    logic [RECT_H_W-1:0] rect_h;
    logic [COLOR_W-1:0]  color;
    logic [BIDX_W-1:0]   byte_index;
    logic                calm;
  } draw_req_t;

  typedef struct {
    logic [DATA_W-1:0]   read_data;
    logic [STATUS_W-1:0] status;
  } reply_t;

  logic clk;
  logic rst_n;

  mpfb_in_if  in_chan ();
  mpfb_out_if out_chan ();

  mono_page_framebuffer_draw_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  logic [DATA_W-1:0] pixels [FB_BYTES];

  draw_req_t cmd_backlog [$];
  reply_t    owed_replies [$];
  draw_req_t cur_req;

  bit req_held;
  bit req_taken;
  bit reply_taken;
  bit stall_armed;
  bit calm_now;
  int send_gap;
  int hold_gap;
  int mismatches;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic void paint(int x, int y, logic [COLOR_W-1:0] col);
    int idx;
    logic [DATA_W-1:0] mask;
    if (x >= SCR_W || y >= SCR_H) return;
    idx  = (y / PAGE_ROWS) * SCR_W + x;
    mask = 8'd1 << (y % PAGE_ROWS);
    case (col)
      PEN_OFF:  pixels[idx] = pixels[idx] & ~mask;
      PEN_ON:   pixels[idx] = pixels[idx] | mask;
      PEN_FLIP: pixels[idx] = pixels[idx] ^ mask;
      default: ;
    endcase
  endfunction

  function automatic reply_t apply_command(draw_req_t r);
    int xa, ya, xb, yb, w, h, t;
    reply_t rep;
    xa  = int'(r.x_a);
    ya  = int'(r.y_a);
    xb  = int'(r.x_b);
    yb  = int'(r.y_b);
    w   = int'(r.rect_w);
    h   = int'(r.rect_h);
    rep = '{read_data: '0, status: '0};
    case (r.command)
      CMD_CLEAR: foreach (pixels[i]) pixels[i] = '0;
      CMD_FILL:  foreach (pixels[i]) pixels[i] = FILL_ONES;
      CMD_PIXEL: begin
        if (xa >= SCR_W || ya >= SCR_H) rep.status = 1'b1;
        else paint(xa, ya, r.color);
      end
      CMD_HLINE: begin
        if (xa > xb) begin
          t  = xa;
          xa = xb;
          xb = t;
        end
        if (xb >= SCR_W || ya >= SCR_H) rep.status = 1'b1;
        else for (int i = xa; i <= xb; i++) paint(i, ya, r.color);
      end
      CMD_VLINE: begin
        if (ya > yb) begin
          t  = ya;
          ya = yb;
          yb = t;
        end
        if (xa >= SCR_W || yb >= SCR_H) rep.status = 1'b1;
        else for (int j = ya; j <= yb; j++) paint(xa, j, r.color);
      end
      CMD_RECT: begin
        if (xa >= SCR_W || ya >= SCR_H || xa + w > SCR_W || ya + h > SCR_H) begin
          rep.status = 1'b1;
        end else begin
          for (int i = xa; i < xa + w; i++)
            for (int j = ya; j < ya + h; j++) paint(i, j, r.color);
        end
      end
      CMD_READ: begin
        if (int'(r.byte_index) >= FB_BYTES) rep.status = 1'b1;
        else rep.read_data = pixels[r.byte_index];
      end
      default: ;
    endcase
    return rep;
  endfunction

  function automatic draw_req_t rand_req();
    draw_req_t r;
    r.command    = CMD_W'($urandom_range(0, 7));
    r.x_a        = X_W'($urandom_range(0, 127));
    r.y_a        = Y_W'($urandom_range(0, 63));
    r.x_b        = X_W'($urandom_range(0, 127));
    r.y_b        = Y_W'($urandom_range(0, 63));
    r.rect_w     = RECT_W_W'($urandom_range(0, 255));
    r.rect_h     = RECT_H_W'($urandom_range(0, 127));
    r.color      = COLOR_W'($urandom_range(0, 3));
    r.byte_index = BIDX_W'($urandom_range(0, 1023));
    r.calm       = 1'b0;
    return r;
  endfunction

  task automatic push_cmd(logic [CMD_W-1:0] cmd, int xa, int ya, int xb, int yb,
                          int w, int h, logic [COLOR_W-1:0] col, int bidx);
    draw_req_t r;
    r.command    = cmd;
    r.x_a        = X_W'(xa);
    r.y_a        = Y_W'(ya);
    r.x_b        = X_W'(xb);
    r.y_b        = Y_W'(yb);
    r.rect_w     = RECT_W_W'(w);
    r.rect_h     = RECT_H_W'(h);
    r.color      = col;
    r.byte_index = BIDX_W'(bidx);
    r.calm       = 1'b0;
    cmd_backlog.push_back(r);
  endtask

  // driver: one item held on the input channel until it is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (req_taken) begin
        req_taken = 1'b0;
        req_held  = 1'b0;
        send_gap  = cur_req.calm ? 0 : int'($urandom_range(0, MAX_IDLE));
      end
      if (!req_held) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (cmd_backlog.size() > 0) begin
          cur_req  = cmd_backlog.pop_front();
          req_held = 1'b1;
          calm_now = cur_req.calm;
        end
      end
      in_chan.valid      <= req_held;
      in_chan.command    <= cur_req.command;
      in_chan.x_a        <= cur_req.x_a;
      in_chan.y_a        <= cur_req.y_a;
      in_chan.x_b        <= cur_req.x_b;
      in_chan.y_b        <= cur_req.y_b;
      in_chan.rect_w     <= cur_req.rect_w;
      in_chan.rect_h     <= cur_req.rect_h;
      in_chan.color      <= cur_req.color;
      in_chan.byte_index <= cur_req.byte_index;
    end
  end

  // result side stall, drawn once per presented item
  always @(negedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (reply_taken) begin
        reply_taken = 1'b0;
        stall_armed = 1'b0;
      end
      if (out_chan.valid && !stall_armed) begin
        stall_armed = 1'b1;
        hold_gap    = calm_now ? 0 : int'($urandom_range(0, MAX_IDLE));
      end
      if (stall_armed && hold_gap > 0) begin
        hold_gap--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // monitor: predict on accepted commands, check accepted replies
  always @(posedge clk) begin
    reply_t want;
    if (rst_n && in_chan.valid && in_chan.ready) begin
      owed_replies.push_back(apply_command(cur_req));
      req_taken = 1'b1;
    end
    if (rst_n && out_chan.valid && out_chan.ready) begin
      reply_taken = 1'b1;
      if (owed_replies.size() == 0) begin
        $display("%0t: unexpected reply, expected none, actual data %02h status %0d",
                 $time, out_chan.read_data, out_chan.status);
        mismatches++;
      end else begin
        want = owed_replies.pop_front();
        if (out_chan.read_data !== want.read_data) begin
          $display("%0t: read_data mismatch, expected %02h, actual %02h",
                   $time, want.read_data, out_chan.read_data);
          mismatches++;
        end
        if (out_chan.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, out_chan.status);
          mismatches++;
        end
      end
    end
  end

  initial begin
    draw_req_t r;
    int pick;
    int sub;
    bit calm_seg;

    rst_n              = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.command    = '0;
    in_chan.x_a        = '0;
    in_chan.y_a        = '0;
    in_chan.x_b        = '0;
    in_chan.y_b        = '0;
    in_chan.rect_w     = '0;
    in_chan.rect_h     = '0;
    in_chan.color      = '0;
    in_chan.byte_index = '0;
    out_chan.ready     = 1'b0;
    cur_req            = '{default: '0};
    foreach (pixels[i]) pixels[i] = '0;

    // directed part
    push_cmd(CMD_READ,  0,   0,  0,   0,  0,   0,   PEN_OFF,  0);
    push_cmd(CMD_READ,  0,   0,  0,   0,  0,   0,   PEN_OFF,  FB_BYTES - 1);
    push_cmd(CMD_FILL,  0,   0,  0,   0,  0,   0,   PEN_OFF,  0);
    push_cmd(CMD_READ,  0,   0,  0,   0,  0,   0,   PEN_OFF,  0);
    push_cmd(CMD_PIXEL, 0,   0,  0,   0,  0,   0,   PEN_OFF,  0);
    push_cmd(CMD_PIXEL, 127, 63, 0,   0,  0,   0,   PEN_FLIP, 0);
    push_cmd(CMD_READ,  0,   0,  0,   0,  0,   0,   PEN_OFF,  0);
    push_cmd(CMD_READ,  0,   0,  0,   0,  0,   0,   PEN_OFF,  FB_BYTES - 1);
    push_cmd(CMD_CLEAR, 0,   0,  0,   0,  0,   0,   PEN_OFF,  0);
    push_cmd(CMD_PIXEL, 127, 63, 0,   0,  0,   0,   PEN_ON,   0);
    push_cmd(CMD_PIXEL, 64,  20, 0,   0,  0,   0,   PEN_NONE, 0);
    // line ends given in reverse order, then a no-pen line and a one-point line
    push_cmd(CMD_HLINE, 127, 0,  0,   0,  0,   0,   PEN_ON,   0);
    push_cmd(CMD_VLINE, 0,   63, 0,   0,  0,   0,   PEN_FLIP, 0);
    push_cmd(CMD_HLINE, 10,  33, 90,  0,  0,   0,   PEN_NONE, 0);
    push_cmd(CMD_VLINE, 70,  17, 0,   17, 0,   0,   PEN_ON,   0);
    push_cmd(CMD_READ,  0,   0,  0,   0,  0,   0,   PEN_OFF,  SCR_W * (PAGES - 1));
    push_cmd(CMD_RECT,  0,   0,  0,   0,  128, 64,  PEN_FLIP, 0);
    // empty rectangles, then one that reaches the right and bottom edges exactly
    push_cmd(CMD_RECT,  5,   5,  0,   0,  0,   10,  PEN_ON,   0);
    push_cmd(CMD_RECT,  5,   5,  0,   0,  10,  0,   PEN_ON,   0);
    push_cmd(CMD_RECT,  100, 0,  0,   0,  28,  64,  PEN_OFF,  0);
    // rectangles running off screen, then a no-op command and a read
    push_cmd(CMD_RECT,  100, 0,  0,   0,  29,  1,   PEN_ON,   0);
    push_cmd(CMD_RECT,  0,   1,  0,   0,  1,   64,  PEN_ON,   0);
    push_cmd(CMD_RECT,  127, 63, 127, 63, 255, 127, PEN_NONE, 1023);
    push_cmd(CMD_NOP,   127, 63, 127, 63, 255, 127, PEN_NONE, 1023);
    push_cmd(CMD_READ,  0,   0,  0,   0,  0,   0,   PEN_OFF,  FB_BYTES / 2);

    // random part
    calm_seg = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % SEGMENT_LEN == 0) calm_seg = ($urandom_range(0, 3) == 0);
      r      = rand_req();
      r.calm = calm_seg;
      pick   = int'($urandom_range(0, 99));
      if (pick < 2) begin
        r.command = ($urandom_range(0, 1) == 1) ? CMD_CLEAR : CMD_FILL;
      end else if (pick < 3) begin
        r.command = CMD_NOP;
      end else if (pick < 33) begin
        r.command = CMD_READ;
      end else if (pick < 48) begin
        r.command = CMD_PIXEL;
      end else if (pick < 61) begin
        r.command = CMD_HLINE;
      end else if (pick < 74) begin
        r.command = CMD_VLINE;
      end else begin
        r.command = CMD_RECT;
        sub       = int'($urandom_range(0, 19));
        if (sub == 1) begin
          r.rect_w = RECT_W_W'(SCR_W - int'(r.x_a));
          r.rect_h = RECT_H_W'(SCR_H - int'(r.y_a));
        end else if (sub < 5) begin
          // corner near the far edge, extent right at or one past it
          r.x_a    = X_W'($urandom_range(SCR_W - 16, SCR_W - 1));
          r.y_a    = Y_W'($urandom_range(SCR_H - 16, SCR_H - 1));
          r.rect_w = RECT_W_W'(SCR_W - int'(r.x_a) + int'($urandom_range(0, 1)));
          r.rect_h = RECT_H_W'(SCR_H - int'(r.y_a) + int'($urandom_range(0, 1)));
        end else if (sub > 0) begin
          r.rect_w = RECT_W_W'($urandom_range(0, 12));
          r.rect_h = RECT_H_W'($urandom_range(0, 12));
        end
      end
      cmd_backlog.push_back(r);
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (cmd_backlog.size() > 0 || req_held) @(posedge clk);
    while (owed_replies.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
